>>> rtl/lvst_pkg.sv
// lvst_pkg: shared constants, types and codes of the lowest-index value search table
// no dependencies; used by the interfaces and every rtl module
`default_nettype none

package lvst_pkg;

  localparam int SLOTS      = 1024;
  localparam int VALUE_BITS = 30;
  localparam int ADDR_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  // fixed field widths of the channels
  localparam int CMD_W   = 1;
  localparam int INDEX_W = 10;
  localparam int VALUE_W = 30;

  localparam logic [CMD_W-1:0] CMD_CHANGE = 1'b0;
  localparam logic [CMD_W-1:0] CMD_FIND   = 1'b1;

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(SLOTS - 1);

  typedef struct packed {
    logic                  valid;
    logic [VALUE_BITS-1:0] value;
  } word_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    word_t             wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

>>> rtl/lvst_if.sv
// lvst_in_if / lvst_out_if: valid/ready channels for command beats and result beats
// depends on lvst_pkg for field widths
`default_nettype none

interface lvst_in_if;
  logic                            valid;
  logic                            ready;
  logic [lvst_pkg::CMD_W-1:0]      cmd;
  logic [lvst_pkg::INDEX_W-1:0]    slot_index;
  logic [lvst_pkg::VALUE_W-1:0]    value;

  modport source (output valid, cmd, slot_index, value, input ready);
  modport sink   (input valid, cmd, slot_index, value, output ready);
endinterface

interface lvst_out_if;
  logic                         valid;
  logic                         ready;
  logic                         found;
  logic [lvst_pkg::INDEX_W-1:0] lowest_slot;

  modport source (output valid, found, lowest_slot, input ready);
  modport sink   (input valid, found, lowest_slot, output ready);
endinterface

`default_nettype wire

>>> rtl/lvst_slot_mem.sv
// lvst_slot_mem: slot table memory, one write and one registered read per cycle
// each word holds the slot's valid bit and value; depends on lvst_pkg
`default_nettype none

module lvst_slot_mem (
  input  wire logic               clk,
  input  wire lvst_pkg::mem_req_t req,
  output lvst_pkg::word_t         rdata
);

  lvst_pkg::word_t mem [lvst_pkg::SLOTS];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/lvst_ctrl.sv
// lvst_ctrl: clearing pass, change writes, find scan and result register
// drives lvst_slot_mem through a mem_req_t; depends on lvst_pkg and lvst_if
`default_nettype none

module lvst_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  lvst_in_if.sink                 req,
  lvst_out_if.source              rsp,
  output lvst_pkg::mem_req_t      mem_req,
  input  wire lvst_pkg::word_t    mem_rdata
);

  lvst_pkg::state_t state;
  lvst_pkg::state_t state_next;

  logic [lvst_pkg::ADDR_W-1:0]     clr_cnt;
  logic [lvst_pkg::ADDR_W-1:0]     scan_addr;
  logic                            issuing;
  logic                            rd_pend;
  logic [lvst_pkg::ADDR_W-1:0]     rd_tag;
  logic [lvst_pkg::VALUE_BITS-1:0] key;
  logic                            res_found;
  logic [lvst_pkg::INDEX_W-1:0]    res_slot;
  logic                            out_valid;
  logic                            out_found;
  logic [lvst_pkg::INDEX_W-1:0]    out_slot;

  logic accept;
  logic in_range;
  logic hit;
  logic scan_done;
  logic out_free;

  assign accept    = req.valid && req.ready;
  assign in_range  = {32'd0, req.slot_index} < 42'(lvst_pkg::SLOTS);
  assign hit       = rd_pend && mem_rdata.valid && (mem_rdata.value == key);
  assign scan_done = hit || (rd_pend && (rd_tag == lvst_pkg::LAST_ADDR));
  assign out_free  = !out_valid || rsp.ready;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      lvst_pkg::ST_CLEAR: begin
        if (clr_cnt == lvst_pkg::LAST_ADDR) state_next = lvst_pkg::ST_IDLE;
      end
      lvst_pkg::ST_IDLE: begin
        if (accept && (req.cmd == lvst_pkg::CMD_FIND)) state_next = lvst_pkg::ST_SCAN;
      end
      lvst_pkg::ST_SCAN: begin
        if (scan_done) state_next = lvst_pkg::ST_DONE;
      end
      lvst_pkg::ST_DONE: begin
        if (out_free) state_next = lvst_pkg::ST_IDLE;
      end
      default: state_next = lvst_pkg::ST_CLEAR;
    endcase
  end

  // outputs
  always_comb begin
    req.ready     = 1'b0;
    mem_req.we    = 1'b0;
    mem_req.waddr = clr_cnt;
    mem_req.wdata = '0;
    mem_req.re    = 1'b0;
    mem_req.raddr = scan_addr;
    unique case (state)
      lvst_pkg::ST_CLEAR: begin
        mem_req.we = 1'b1;
      end
      lvst_pkg::ST_IDLE: begin
        req.ready           = 1'b1;
        mem_req.we          = req.valid && (req.cmd == lvst_pkg::CMD_CHANGE) && in_range;
        mem_req.waddr       = lvst_pkg::ADDR_W'(req.slot_index);
        mem_req.wdata.valid = 1'b1;
        mem_req.wdata.value = lvst_pkg::VALUE_BITS'(req.value);
      end
      lvst_pkg::ST_SCAN: begin
        mem_req.re = issuing;
      end
      lvst_pkg::ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= lvst_pkg::ST_CLEAR;
      clr_cnt <= '0;
      issuing <= 1'b0;
      rd_pend <= 1'b0;
    end else begin
      state <= state_next;
      if (state == lvst_pkg::ST_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (state == lvst_pkg::ST_IDLE) begin
        issuing <= accept && (req.cmd == lvst_pkg::CMD_FIND);
        rd_pend <= 1'b0;
      end else if (state == lvst_pkg::ST_SCAN) begin
        if (scan_done) begin
          issuing <= 1'b0;
          rd_pend <= 1'b0;
        end else begin
          rd_pend <= issuing;
          if (issuing && (scan_addr == lvst_pkg::LAST_ADDR)) issuing <= 1'b0;
        end
      end
    end
  end

  // scan datapath
  always_ff @(posedge clk) begin
    if (state == lvst_pkg::ST_IDLE) begin
      scan_addr <= '0;
      key       <= lvst_pkg::VALUE_BITS'(req.value);
    end else if (state == lvst_pkg::ST_SCAN) begin
      rd_tag <= scan_addr;
      if (issuing) scan_addr <= scan_addr + 1'b1;
      if (scan_done) begin
        res_found <= hit;
        res_slot  <= hit ? lvst_pkg::INDEX_W'(rd_tag) : '0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == lvst_pkg::ST_DONE) && out_free) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == lvst_pkg::ST_DONE) && out_free) begin
      out_found <= res_found;
      out_slot  <= res_slot;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.found       = out_found;
  assign rsp.lowest_slot = out_slot;

endmodule

`default_nettype wire

>>> rtl/lowest_index_value_search_table.sv
// lowest_index_value_search_table: slot table with lowest-index match search
// top level; instantiates lvst_ctrl and lvst_slot_mem, depends on lvst_pkg and lvst_if
//
//   channel  dir  beat fields                      notes
//   req      in   cmd, slot_index, value           change: no result; find: one result
//   rsp      out  found, lowest_slot               one beat per find
//
// after reset a clearing pass over all SLOTS (1024) slots writes every slot invalid; req.ready
// stays low meanwhile. a change writes its slot as it is accepted. a find scans the memory
// one slot per cycle through its single read port, up to the first hit or the last slot.
// one command is in work at a time; a result waiting in the output register holds back
// the next find's completion, and with it the accept of new beats.
`default_nettype none

module lowest_index_value_search_table (
  input  wire logic  clk,
  input  wire logic  rst,
  lvst_in_if.sink    req,
  lvst_out_if.source rsp
);

  lvst_pkg::mem_req_t mem_req;
  lvst_pkg::word_t    mem_rdata;

  lvst_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rsp       (rsp),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata)
  );

  lvst_slot_mem u_mem (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

endmodule

`default_nettype wire
